/* sv/bmp_pkg.sv */
// Shared types and constants for the bounded message pool.
package bmp_pkg;

  localparam logic signed [31:0] ANY_QUEUE = -32'sd1;

  // One stored message
  typedef struct packed {
    logic [31:0]        id;
    logic signed [31:0] queue;
    logic [15:0]        payload;
  } entry_t;

  // Request actions
  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_EVICT = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Reported event kinds
  typedef enum logic [1:0] {
    EV_NEW     = 2'd0,
    EV_CLEAR   = 2'd1,
    EV_EVICT   = 2'd2,
    EV_NOTHING = 2'd3
  } event_kind_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_REMOVE = 2'd1,
    CELL_APPEND = 2'd2,
    CELL_PUSH   = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic               use_id;
    logic [31:0]        key_id;
    logic signed [31:0] key_queue;
    entry_t             new_entry;
  } cell_ctl_t;

  // One result item
  typedef struct packed {
    event_kind_t        kind;
    logic [31:0]        id;
    logic signed [31:0] queue;
    logic [15:0]        payload;
    logic               dropped;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_EMIT = 2'd2
  } state_t;

endpackage

/* sv/bmp_req_if.sv */
// Request channel: valid/ready handshake with the pool request fields.
interface bmp_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [31:0]        msg_id;
  logic signed [31:0] queue_id;
  logic               text_empty;
  logic [15:0]        payload_handle;

  modport source (output valid, action, msg_id, queue_id, text_empty, payload_handle,
                  input ready);
  modport sink (input valid, action, msg_id, queue_id, text_empty, payload_handle,
                output ready);
endinterface

/* sv/bmp_rsp_if.sv */
// Result channel: valid/ready handshake with the pool event fields.
interface bmp_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic [31:0]        out_msg_id;
  logic signed [31:0] out_queue_id;
  logic [15:0]        out_payload;
  logic               dropped_oldest;

  modport source (output valid, event_kind, out_msg_id, out_queue_id, out_payload,
                  dropped_oldest, input ready);
  modport sink (input valid, event_kind, out_msg_id, out_queue_id, out_payload,
                dropped_oldest, output ready);
endinterface

/* sv/bmp_cell.sv */
// One slot of the pool: holds an entry and shifts toward the oldest end.
module bmp_cell
  import bmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  logic      left_valid,
  input  logic      sel_in,
  input  entry_t    pick_in,
  input  logic      right_valid,
  input  entry_t    right_entry,
  output logic      sel_out,
  output entry_t    pick_out,
  output logic      valid,
  output entry_t    entry
);

  logic hit;
  logic load_right;
  logic load_new;

  // Key match against the stored entry
  always_comb begin
    hit = valid
          && (ctl.key_queue == ANY_QUEUE || ctl.key_queue == entry.queue)
          && (!ctl.use_id || ctl.key_id == entry.id);
    sel_out  = sel_in | hit;
    pick_out = (!sel_in && hit) ? entry : pick_in;
  end

  // Per-command load decisions
  always_comb begin
    load_right = 1'b0;
    load_new   = 1'b0;
    unique case (ctl.cmd)
      CELL_HOLD:   ;
      CELL_REMOVE: load_right = sel_out;
      CELL_PUSH:   load_right = 1'b1;
      CELL_APPEND: load_new   = left_valid && !valid;
      default:     ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_right) begin
      valid <= right_valid;
    end else if (load_new) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_right) begin
      entry <= right_entry;
    end else if (load_new) begin
      entry <= ctl.new_entry;
    end
  end

endmodule

/* sv/bounded_message_pool.sv */
// Bounded message pool top level: request decode, sequencer and the cell chain.
//
// Ordered pool of POOL_LIMIT+1 messages, oldest at cell 0. Requests enter on
// req (valid/ready); one result item per request leaves on rsp (valid/ready).
// Add appends an entry (dropping the oldest when full), clear removes every
// entry matching id and queue, evict removes and returns the oldest entry
// matching the queue. An add with empty text and a nonzero id is a clear.
//
// A request is taken only while the sequencer is idle. Each accepted request
// passes from idle to an execute state and then to an emit state; add, evict
// and the unused action execute once, while clear stays in execute as long as
// a matching entry remains, since the chain removes one matching entry per
// cycle as each cell pulls from its right-hand neighbor. The emit state loads
// the result item into the output register when that register is free.
// The result goes to an output register. A new request is accepted while it
// waits; if the receiver stalls, the next result waits in the sequencer until
// the output register frees, and no further request is taken meanwhile.
// Reset (synchronous, active high) empties the pool and drops any pending
// result; entry contents are not cleared, only the per-cell valid bits.
module bounded_message_pool
  import bmp_pkg::*;
#(
  parameter int POOL_LIMIT = 4
) (
  input logic     clk,
  input logic     rst,
  bmp_req_if.sink   req,
  bmp_rsp_if.source rsp
);

  localparam int DEPTH = POOL_LIMIT + 1;

  state_t    state, state_next;
  action_t   op, op_next;
  entry_t    key, key_next;
  rsp_t      res, res_next;
  rsp_t      out_data;
  logic      out_valid;
  logic      out_load;
  cell_ctl_t ctl;
  logic      full;

  logic   sel_w   [DEPTH+1];
  entry_t pick_w  [DEPTH+1];
  logic   valid_w [DEPTH];
  entry_t entry_w [DEPTH];

  assign full = valid_w[DEPTH-1];
  assign sel_w[0]  = 1'b0;
  assign pick_w[0] = '0;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   lv;
    logic   rv;
    entry_t re;
    if (i == 0) begin : g_first
      assign lv = 1'b1;
    end else begin : g_mid
      assign lv = valid_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rv = (ctl.cmd == CELL_PUSH);
      assign re = ctl.new_entry;
    end else begin : g_inner
      assign rv = valid_w[i+1];
      assign re = entry_w[i+1];
    end
    bmp_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_valid  (lv),
      .sel_in      (sel_w[i]),
      .pick_in     (pick_w[i]),
      .right_valid (rv),
      .right_entry (re),
      .sel_out     (sel_w[i+1]),
      .pick_out    (pick_w[i+1]),
      .valid       (valid_w[i]),
      .entry       (entry_w[i])
    );
  end

  assign req.ready = (state == ST_IDLE);
  assign out_load  = (state == ST_EMIT) && (!out_valid || rsp.ready);

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op  <= op_next;
    key <= key_next;
    res <= res_next;
  end

  // Next state, cell command and result
  always_comb begin
    state_next = state;
    op_next    = op;
    key_next   = key;
    res_next   = res;
    ctl.cmd       = CELL_HOLD;
    ctl.use_id    = 1'b0;
    ctl.key_id    = key.id;
    ctl.key_queue = key.queue;
    ctl.new_entry = key;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          key_next.id      = req.msg_id;
          key_next.queue   = req.queue_id;
          key_next.payload = req.payload_handle;
          op_next          = action_t'(req.action);
          // empty text with an id means clear
          if (req.action == ACT_ADD && req.text_empty && req.msg_id != 32'd0) begin
            op_next = ACT_CLEAR;
          end
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_next   = '{kind: EV_NOTHING, id: '0, queue: '0, payload: '0, dropped: 1'b0};
        state_next = ST_EMIT;
        unique case (op)
          ACT_ADD: begin
            ctl.cmd       = full ? CELL_PUSH : CELL_APPEND;
            res_next.kind    = EV_NEW;
            res_next.queue   = key.queue;
            res_next.dropped = full;
          end
          ACT_CLEAR: begin
            // one matching entry leaves per cycle until none remain
            ctl.cmd    = CELL_REMOVE;
            ctl.use_id = 1'b1;
            if (sel_w[DEPTH]) begin
              state_next = ST_EXEC;
            end
            res_next.kind  = EV_CLEAR;
            res_next.id    = key.id;
            res_next.queue = key.queue;
          end
          ACT_EVICT: begin
            ctl.cmd = CELL_REMOVE;
            if (sel_w[DEPTH]) begin
              res_next.kind    = EV_EVICT;
              res_next.id      = pick_w[DEPTH].id;
              res_next.queue   = pick_w[DEPTH].queue;
              res_next.payload = pick_w[DEPTH].payload;
            end
          end
          ACT_NONE: ;
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.event_kind     = out_data.kind;
  assign rsp.out_msg_id     = out_data.id;
  assign rsp.out_queue_id   = out_data.queue;
  assign rsp.out_payload    = out_data.payload;
  assign rsp.dropped_oldest = out_data.dropped;

endmodule
